// ===== hdl/tdac_pkg.sv =====
// shared constants for the tilt and distance alert conditioner
package tdac_pkg;

    // field widths
    localparam int ECHO_W   = 15;
    localparam int TIME_W   = 32;
    localparam int DIST_W   = 18;
    localparam int THR_W    = 18;
    localparam int DEB_W    = 16;
    localparam int CNT_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 18;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    // echo time to cm with 8 fraction bits: (echo * 1124) >> 8
    localparam int SCALE_W = 11;
    localparam logic [SCALE_W-1:0] ECHO_SCALE = 11'd1124;
    localparam int PROD_W = ECHO_W + SCALE_W;
    localparam int FRAC_SHIFT = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_COUNT     = 2'd2;

    // configuration reset values
    localparam logic [THR_W-1:0] THRESHOLD_RST = 18'd614;
    localparam logic [DEB_W-1:0] DEBOUNCE_RST  = 16'd300;
    localparam logic [CNT_W-1:0] STABLE_RST    = 8'd5;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    // result fields carried down the pipeline
    typedef struct packed {
        logic timed_out;
        logic active;
    } t_flags;

endpackage

// ===== hdl/tdac_cell.sv =====
// one sample cell of the window shift line
module tdac_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic [tdac_pkg::DIST_W-1:0] i_d,
    output logic [tdac_pkg::DIST_W-1:0] o_q
);

    logic [tdac_pkg::DIST_W-1:0] r_q;

    // take the neighbor's sample on a shift, window starts cleared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ===== hdl/tdac_debounce.sv =====
// time based debounce and low count of the tilt switch
module tdac_debounce (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_level,
    input  logic [tdac_pkg::TIME_W-1:0] i_now,
    input  logic [tdac_pkg::DEB_W-1:0]  i_debounce_ms,
    input  logic [tdac_pkg::CNT_W-1:0]  i_stable_count,
    output logic                        o_active
);

    logic [tdac_pkg::TIME_W-1:0] r_last_time;
    logic [tdac_pkg::CNT_W-1:0]  r_low_count;
    logic [tdac_pkg::TIME_W-1:0] elapsed;
    logic                        take;
    logic [tdac_pkg::CNT_W-1:0]  n_low_count;

    // reading is taken when more than the interval has passed, modulo wrap
    always_comb begin
        elapsed = i_now - r_last_time;
        take    = elapsed > {{(tdac_pkg::TIME_W-tdac_pkg::DEB_W){1'b0}}, i_debounce_ms};
        n_low_count = r_low_count;
        if (take) begin
            if (i_level) begin
                n_low_count = '0;
            end else if (r_low_count != tdac_pkg::CNT_MAX) begin
                n_low_count = r_low_count + 1'b1;
            end
        end
    end

    assign o_active = n_low_count >= i_stable_count;

    // state moves only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_low_count <= '0;
        end else if (i_accept) begin
            r_low_count <= n_low_count;
            if (take) begin
                r_last_time <= i_now;
            end
        end
    end

endmodule

// ===== hdl/tilt_and_distance_alert_conditioner.sv =====
// top level of the tilt and distance alert conditioner
// Takes one request per clock cycle while o_s_tready is high and gives one
// result per request. The window is a shift line of WINDOW_LEN sample cells
// and a running sum that adds the new sample and drops the oldest, followed
// by a reciprocal multiply that forms the mean. Stages are: echo scaling and
// switch debounce, window update, mean multiply, then change and alert into
// the output register. Each stage holds its item while the one after it is
// full, so a result waiting at the output does not stop earlier stages from
// filling. Configuration writes take effect at once and are meant to be made
// while no request is in flight.
module tilt_and_distance_alert_conditioner #(
    parameter int WINDOW_LEN = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request side
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // echo_us[14:0], switch_level[15], now_ms[47:16]
    input  logic [tdac_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // result side
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // distance_avg[17:0], distance_change[35:18], switch_active[36],
    // alert[37], timed_out[38], zero[39]
    output logic [tdac_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [tdac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tdac_pkg::CFG_DAT_W-1:0]  i_cfg_wdata
);

    localparam int LOG_N  = $clog2(WINDOW_LEN);
    localparam int SUM_W  = tdac_pkg::DIST_W + LOG_N;
    localparam int SH     = SUM_W + LOG_N;
    localparam int MPROD_W = 2 * SUM_W + 1;
    localparam logic [63:0] MUL_FULL =
        ((64'd1 << SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [SUM_W:0] MUL = MUL_FULL[SUM_W:0];

    // configuration registers
    logic [tdac_pkg::THR_W-1:0] r_threshold;
    logic [tdac_pkg::DEB_W-1:0] r_debounce_ms;
    logic [tdac_pkg::CNT_W-1:0] r_stable_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= tdac_pkg::THRESHOLD_RST;
            r_debounce_ms  <= tdac_pkg::DEBOUNCE_RST;
            r_stable_count <= tdac_pkg::STABLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tdac_pkg::CFG_CHANGE_THRESHOLD: r_threshold    <= i_cfg_wdata;
                tdac_pkg::CFG_DEBOUNCE_MS:
                    r_debounce_ms  <= i_cfg_wdata[tdac_pkg::DEB_W-1:0];
                tdac_pkg::CFG_STABLE_COUNT:
                    r_stable_count <= i_cfg_wdata[tdac_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // request fields
    logic [tdac_pkg::ECHO_W-1:0] in_echo;
    logic                        in_level;
    logic [tdac_pkg::TIME_W-1:0] in_now;

    assign in_echo  = i_s_tdata[tdac_pkg::ECHO_W-1:0];
    assign in_level = i_s_tdata[tdac_pkg::ECHO_W];
    assign in_now   = i_s_tdata[tdac_pkg::ECHO_W+1 +: tdac_pkg::TIME_W];

    // stage valids and load enables, each stage loads when empty or draining
    logic r0_valid, r1_valid, r2_valid, r3_valid;
    logic ld0, ld1, ld2, ld3;
    logic accept;

    assign ld3 = !r3_valid || i_m_tready;
    assign ld2 = !r2_valid || ld3;
    assign ld1 = !r1_valid || ld2;
    assign ld0 = !r0_valid || ld1;
    assign o_s_tready = ld0;
    assign accept = i_s_tvalid && ld0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (ld0) r0_valid <= i_s_tvalid;
            if (ld1) r1_valid <= r0_valid;
            if (ld2) r2_valid <= r1_valid;
            if (ld3) r3_valid <= r2_valid;
        end
    end

    // stage 0: switch debounce and echo scaling
    logic                         active;
    logic [tdac_pkg::PROD_W-1:0]  echo_prod;
    logic [tdac_pkg::DIST_W-1:0]  r0_sample;
    tdac_pkg::t_flags             r0_flags;

    tdac_debounce u_debounce (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_level        (in_level),
        .i_now          (in_now),
        .i_debounce_ms  (r_debounce_ms),
        .i_stable_count (r_stable_count),
        .o_active       (active)
    );

    assign echo_prod = tdac_pkg::PROD_W'(in_echo) * tdac_pkg::PROD_W'(tdac_pkg::ECHO_SCALE);

    always_ff @(posedge i_clk) begin
        if (ld0) begin
            r0_sample          <= echo_prod[tdac_pkg::FRAC_SHIFT +: tdac_pkg::DIST_W];
            r0_flags.timed_out <= in_echo == '0;
            r0_flags.active    <= active;
        end
    end

    // stage 1: shift line of sample cells and running sum
    logic                         shift;
    logic [tdac_pkg::DIST_W-1:0]  cell_q [WINDOW_LEN];
    logic [SUM_W-1:0]             r_sum;
    logic [SUM_W-1:0]             n_sum;
    tdac_pkg::t_flags             r1_flags;

    assign shift = ld1 && r0_valid && !r0_flags.timed_out;

    genvar g;
    generate
        for (g = 0; g < WINDOW_LEN; g++) begin : g_cell
            if (g == 0) begin : g_head
                tdac_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (shift),
                    .i_d     (r0_sample),
                    .o_q     (cell_q[g])
                );
            end else begin : g_body
                tdac_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (shift),
                    .i_d     (cell_q[g-1]),
                    .o_q     (cell_q[g])
                );
            end
        end
    endgenerate

    // new sample in, oldest sample out
    assign n_sum = r_sum + SUM_W'(r0_sample) - SUM_W'(cell_q[WINDOW_LEN-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (shift) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r1_flags <= r0_flags;
        end
    end

    // stage 2: mean by reciprocal multiply
    logic [MPROD_W-1:0] r2_prod;
    tdac_pkg::t_flags   r2_flags;

    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r2_prod  <= MPROD_W'(r_sum) * MPROD_W'(MUL);
            r2_flags <= r1_flags;
        end
    end

    // stage 3: distance, change, alert into the output register
    logic [tdac_pkg::DIST_W-1:0] avg_dist;
    logic [tdac_pkg::DIST_W-1:0] change;
    logic [tdac_pkg::DIST_W-1:0] r_prev;
    logic [tdac_pkg::DIST_W-1:0] r3_dist;
    logic [tdac_pkg::DIST_W-1:0] r3_change;
    logic                        r3_alert;
    tdac_pkg::t_flags            r3_flags;

    always_comb begin
        avg_dist = r2_flags.timed_out ? r_prev : r2_prod[SH +: tdac_pkg::DIST_W];
        change   = (avg_dist >= r_prev) ? avg_dist - r_prev : r_prev - avg_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (ld3 && r2_valid) begin
            r_prev <= avg_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld3) begin
            r3_dist   <= avg_dist;
            r3_change <= change;
            r3_alert  <= (change >= r_threshold) && !r2_flags.active;
            r3_flags  <= r2_flags;
        end
    end

    // result packing
    assign o_m_tvalid = r3_valid;
    assign o_m_tdata  = {1'b0, r3_flags.timed_out, r3_alert, r3_flags.active,
                         r3_change, r3_dist};

endmodule
